### rtl/ndt_pkg.sv
// Shared widths, defaults and record types for the NAK request dedup table.
package ndt_pkg;

    localparam int SEQ_W             = 32;
    localparam int ADDR_W            = 32;
    localparam int IFACE_W           = 16;
    localparam int DUP_W             = 16;
    localparam int TABLE_DEPTH_DEF   = 16;

    // One stored request together with its duplicate count.
    typedef struct packed {
        logic [SEQ_W-1:0]   low;
        logic [SEQ_W-1:0]   high;
        logic [ADDR_W-1:0]  addr;
        logic [IFACE_W-1:0] iface;
        logic [DUP_W-1:0]   dups;
    } ndt_entry_t;

    // Outcome of one request, handed from the engine to the output register.
    typedef struct packed {
        logic             is_new;
        logic [DUP_W-1:0] dup_count;
        logic [DUP_W-1:0] max_dups;
        logic             evicted;
    } ndt_result_t;

endpackage

### rtl/nak_request_dedup_table.sv
// Top level of the NAK request dedup table: engine, entry memory, output register.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------------
//   request | req_valid, req_stall | seq_low, seq_high, turn_addr, turn_iface
//   result  | rsp_valid, rsp_stall | is_new, dup_count, max_dups, evicted
//
// One request is handled at a time. The engine reads one stored entry per cycle
// from the entry memory, newest first; a miss reads every stored entry, and a match
// ends the search early.
// Reset empties the table through the fill count; the memory is not cleared.
// A new request is taken while a finished result still waits in the output register.
// A stalled result holds the engine only at its final step.
module nak_request_dedup_table #(
    parameter int TABLE_DEPTH = ndt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [ndt_pkg::SEQ_W-1:0]   seq_low,
    input  logic [ndt_pkg::SEQ_W-1:0]   seq_high,
    input  logic [ndt_pkg::ADDR_W-1:0]  turn_addr,
    input  logic [ndt_pkg::IFACE_W-1:0] turn_iface,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic                        is_new,
    output logic [ndt_pkg::DUP_W-1:0]   dup_count,
    output logic [ndt_pkg::DUP_W-1:0]   max_dups,
    output logic                        evicted
);
    import ndt_pkg::*;

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    logic            mem_wr_en;
    logic [IDXW-1:0] mem_wr_addr;
    ndt_entry_t      mem_wr_data;
    logic            mem_rd_en;
    logic [IDXW-1:0] mem_rd_addr;
    ndt_entry_t      mem_rd_data;
    logic            res_valid;
    ndt_result_t     res;
    logic            res_take;
    logic            rsp_valid_reg;
    ndt_result_t     rsp_reg;

    ndt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDXW        (IDXW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ndt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDXW        (IDXW),
        .CNTW        (CNTW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .seq_low     (seq_low),
        .seq_high    (seq_high),
        .turn_addr   (turn_addr),
        .turn_iface  (turn_iface),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign is_new    = rsp_reg.is_new;
    assign dup_count = rsp_reg.dup_count;
    assign max_dups  = rsp_reg.max_dups;
    assign evicted   = rsp_reg.evicted;

    // A duplicate never drops an entry, and a new entry always starts at zero.
    a_dup_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_new || !evicted))
        else $error("duplicate result reports an eviction");

    a_new_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_new) |-> (dup_count == '0))
        else $error("new request reports a nonzero duplicate count");

    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (max_dups >= dup_count))
        else $error("running maximum below reported duplicate count");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second request accepted while one is in progress");

endmodule

### rtl/ndt_mem.sv
// Entry memory: one write port, one read port with a registered read.
module ndt_mem #(
    parameter int TABLE_DEPTH = ndt_pkg::TABLE_DEPTH_DEF,
    parameter int IDXW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDXW-1:0]    wr_addr,
    input  ndt_pkg::ndt_entry_t wr_data,
    input  logic               rd_en,
    input  logic [IDXW-1:0]    rd_addr,
    output ndt_pkg::ndt_entry_t rd_data
);
    import ndt_pkg::*;

    ndt_entry_t mem [TABLE_DEPTH];
    ndt_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ndt_engine.sv
// Search and insert sequencer that walks the circular entry table.
module ndt_engine #(
    parameter int TABLE_DEPTH = ndt_pkg::TABLE_DEPTH_DEF,
    parameter int IDXW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNTW        = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [ndt_pkg::SEQ_W-1:0]   seq_low,
    input  logic [ndt_pkg::SEQ_W-1:0]   seq_high,
    input  logic [ndt_pkg::ADDR_W-1:0]  turn_addr,
    input  logic [ndt_pkg::IFACE_W-1:0] turn_iface,
    output logic                        mem_wr_en,
    output logic [IDXW-1:0]             mem_wr_addr,
    output ndt_pkg::ndt_entry_t         mem_wr_data,
    output logic                        mem_rd_en,
    output logic [IDXW-1:0]             mem_rd_addr,
    input  ndt_pkg::ndt_entry_t         mem_rd_data,
    output logic                        res_valid,
    output ndt_pkg::ndt_result_t        res,
    input  logic                        res_take
);
    import ndt_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_POST} state_t;

    state_t             state_reg, state_next;
    logic [SEQ_W-1:0]   low_reg, low_next;
    logic [SEQ_W-1:0]   high_reg, high_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [IFACE_W-1:0] iface_reg, iface_next;
    logic [IDXW-1:0]    head_reg, head_next;
    logic [CNTW-1:0]    fill_reg, fill_next;
    logic [DUP_W-1:0]   max_reg, max_next;
    logic [CNTW-1:0]    iss_k_reg, iss_k_next;
    logic [IDXW-1:0]    iss_p_reg, iss_p_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDXW-1:0]    cmp_p_reg, cmp_p_next;
    ndt_result_t        res_reg, res_next;

    logic               hit;
    logic [DUP_W-1:0]   new_dups;
    logic [IDXW-1:0]    head_dec;
    logic               full;

    assign hit = cmp_valid_reg
              && (mem_rd_data.low   == low_reg)
              && (mem_rd_data.high  == high_reg)
              && (mem_rd_data.addr  == addr_reg)
              && (mem_rd_data.iface == iface_reg);

    assign new_dups = (mem_rd_data.dups == '1) ? mem_rd_data.dups
                                               : mem_rd_data.dups + 1'b1;
    assign head_dec = (head_reg == '0) ? IDXW'(TABLE_DEPTH - 1) : head_reg - 1'b1;
    assign full     = (fill_reg == CNTW'(TABLE_DEPTH));

    // The read walks logical slots newest first; each compare comes in the cycle after its read.
    assign mem_rd_en   = (state_reg == ST_SEARCH) && (iss_k_reg < fill_reg);
    assign mem_rd_addr = iss_p_reg;

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        addr_next      = addr_reg;
        iface_next     = iface_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        max_next       = max_reg;
        iss_k_next     = iss_k_reg;
        iss_p_next     = iss_p_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_p_next     = cmp_p_reg;
        res_next       = res_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cmp_p_reg;
        mem_wr_data    = mem_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    low_next       = seq_low;
                    high_next      = seq_high;
                    addr_next      = turn_addr;
                    iface_next     = turn_iface;
                    iss_k_next     = '0;
                    iss_p_next     = head_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmp_valid_next = mem_rd_en;
                cmp_p_next     = iss_p_reg;
                if (mem_rd_en)
                begin
                    iss_k_next = CNTW'(iss_k_reg + 1'b1);
                    iss_p_next = (iss_p_reg == IDXW'(TABLE_DEPTH - 1)) ? '0
                                                                       : iss_p_reg + 1'b1;
                end
                if (hit)
                begin
                    mem_wr_en          = 1'b1;
                    mem_wr_data.dups   = new_dups;
                    max_next           = (new_dups > max_reg) ? new_dups : max_reg;
                    res_next.is_new    = 1'b0;
                    res_next.dup_count = new_dups;
                    res_next.max_dups  = (new_dups > max_reg) ? new_dups : max_reg;
                    res_next.evicted   = 1'b0;
                    cmp_valid_next     = 1'b0;
                    state_next         = ST_POST;
                end
                else if (!cmp_valid_reg && !mem_rd_en)
                begin
                    // No match anywhere: the new head slot is the oldest one when full.
                    mem_wr_en          = 1'b1;
                    mem_wr_addr        = head_dec;
                    mem_wr_data.low    = low_reg;
                    mem_wr_data.high   = high_reg;
                    mem_wr_data.addr   = addr_reg;
                    mem_wr_data.iface  = iface_reg;
                    mem_wr_data.dups   = '0;
                    head_next          = head_dec;
                    fill_next          = full ? fill_reg : CNTW'(fill_reg + 1'b1);
                    res_next.is_new    = 1'b1;
                    res_next.dup_count = '0;
                    res_next.max_dups  = max_reg;
                    res_next.evicted   = full;
                    state_next         = ST_POST;
                end
            end
            ST_POST:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            max_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            max_reg       <= max_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        high_reg  <= high_next;
        addr_reg  <= addr_next;
        iface_reg <= iface_next;
        iss_k_reg <= iss_k_next;
        iss_p_reg <= iss_p_next;
        cmp_p_reg <= cmp_p_next;
        res_reg   <= res_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_POST);
    assign res       = res_reg;

endmodule
